// File: rtl/apr_pkg.sv
package apr_pkg;

    localparam int COORD_W   = 32;
    localparam int SIZE_W    = 31;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int COEF_IDX_W = 3;

    localparam logic signed [COORD_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] S32_MIN = 32'sh8000_0000;
    localparam logic [SIZE_W-1:0]         U31_MAX = 31'h7FFF_FFFF;

    localparam logic signed [COORD_W-1:0] COEF_ONE_RST  = 32'sh0001_0000;
    localparam logic signed [COORD_W-1:0] COEF_ZERO_RST = 32'sh0000_0000;

    typedef enum logic [COEF_IDX_W-1:0] {
        COEF_XX = 3'd0,
        COEF_XY = 3'd1,
        COEF_XT = 3'd2,
        COEF_YX = 3'd3,
        COEF_YY = 3'd4,
        COEF_YT = 3'd5
    } coef_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] xx;
        logic signed [COORD_W-1:0] xy;
        logic signed [COORD_W-1:0] xt;
        logic signed [COORD_W-1:0] yx;
        logic signed [COORD_W-1:0] yy;
        logic signed [COORD_W-1:0] yt;
    } coef_set_t;

    // near and far edges of the box (equal in point mode)
    typedef struct packed {
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] y1;
    } corner_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] xx0;
        logic signed [PROD_W-1:0] xx1;
        logic signed [PROD_W-1:0] xy0;
        logic signed [PROD_W-1:0] xy1;
        logic signed [PROD_W-1:0] yx0;
        logic signed [PROD_W-1:0] yx1;
        logic signed [PROD_W-1:0] yy0;
        logic signed [PROD_W-1:0] yy1;
    } prod_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic [SIZE_W-1:0]         out_w;
        logic [SIZE_W-1:0]         out_h;
    } result_t;

endpackage

// File: rtl/apr_if.sv
interface apr_item_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 mode;
    logic signed [apr_pkg::COORD_W-1:0]   pos_x;
    logic signed [apr_pkg::COORD_W-1:0]   pos_y;
    logic [apr_pkg::SIZE_W-1:0]           size_w;
    logic [apr_pkg::SIZE_W-1:0]           size_h;

    modport source (output valid, mode, pos_x, pos_y, size_w, size_h, input ready);
    modport sink (input valid, mode, pos_x, pos_y, size_w, size_h, output ready);
endinterface

interface apr_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [apr_pkg::COORD_W-1:0]   out_x;
    logic signed [apr_pkg::COORD_W-1:0]   out_y;
    logic [apr_pkg::SIZE_W-1:0]           out_w;
    logic [apr_pkg::SIZE_W-1:0]           out_h;

    modport source (output valid, out_x, out_y, out_w, out_h, input ready);
    modport sink (input valid, out_x, out_y, out_w, out_h, output ready);
endinterface

interface apr_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [apr_pkg::COEF_IDX_W-1:0]       index;
    logic [apr_pkg::COORD_W-1:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/apr_coef_regs.sv
module apr_coef_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [apr_pkg::COEF_IDX_W-1:0]  wr_index,
    input  logic [apr_pkg::COORD_W-1:0]     wr_data,
    output apr_pkg::coef_set_t              coef
);

    apr_pkg::coef_set_t coef_reg;
    apr_pkg::coef_set_t coef_next;

    always_comb
    begin
        coef_next = coef_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                apr_pkg::COEF_XX: coef_next.xx = $signed(wr_data);
                apr_pkg::COEF_XY: coef_next.xy = $signed(wr_data);
                apr_pkg::COEF_XT: coef_next.xt = $signed(wr_data);
                apr_pkg::COEF_YX: coef_next.yx = $signed(wr_data);
                apr_pkg::COEF_YY: coef_next.yy = $signed(wr_data);
                apr_pkg::COEF_YT: coef_next.yt = $signed(wr_data);
                default: coef_next = coef_reg;   // unknown index: dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.xx <= apr_pkg::COEF_ONE_RST;
            coef_reg.xy <= apr_pkg::COEF_ZERO_RST;
            coef_reg.xt <= apr_pkg::COEF_ZERO_RST;
            coef_reg.yx <= apr_pkg::COEF_ZERO_RST;
            coef_reg.yy <= apr_pkg::COEF_ONE_RST;
            coef_reg.yt <= apr_pkg::COEF_ZERO_RST;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

// File: rtl/apr_front.sv
// Stage 1: far edges with saturation. Stage 2: eight 32x32 products.
module apr_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic                                mode,
    input  logic signed [apr_pkg::COORD_W-1:0]  pos_x,
    input  logic signed [apr_pkg::COORD_W-1:0]  pos_y,
    input  logic [apr_pkg::SIZE_W-1:0]          size_w,
    input  logic [apr_pkg::SIZE_W-1:0]          size_h,
    input  apr_pkg::coef_set_t                  coef,
    output logic                                out_valid,
    output apr_pkg::prod_t                      prod
);

    logic [apr_pkg::SIZE_W-1:0]          w_eff;
    logic [apr_pkg::SIZE_W-1:0]          h_eff;
    logic signed [apr_pkg::COORD_W:0]    x_far;
    logic signed [apr_pkg::COORD_W:0]    y_far;

    apr_pkg::corner_t corner_reg;
    apr_pkg::corner_t corner_next;
    logic             corner_vld_reg;
    apr_pkg::prod_t   prod_reg;
    apr_pkg::prod_t   prod_next;
    logic             prod_vld_reg;

    // point mode is a rectangle of zero size
    assign w_eff = mode ? size_w : '0;
    assign h_eff = mode ? size_h : '0;

    assign x_far = {pos_x[apr_pkg::COORD_W-1], pos_x} + $signed({2'b00, w_eff});
    assign y_far = {pos_y[apr_pkg::COORD_W-1], pos_y} + $signed({2'b00, h_eff});

    always_comb
    begin
        corner_next.x0 = pos_x;
        corner_next.y0 = pos_y;
        // size is non-negative, so only the top can overflow
        corner_next.x1 = (x_far[apr_pkg::COORD_W] != x_far[apr_pkg::COORD_W-1]) ?
                         apr_pkg::S32_MAX : x_far[apr_pkg::COORD_W-1:0];
        corner_next.y1 = (y_far[apr_pkg::COORD_W] != y_far[apr_pkg::COORD_W-1]) ?
                         apr_pkg::S32_MAX : y_far[apr_pkg::COORD_W-1:0];
    end

    always_comb
    begin
        prod_next.xx0 = apr_pkg::PROD_W'(coef.xx) * apr_pkg::PROD_W'(corner_reg.x0);
        prod_next.xx1 = apr_pkg::PROD_W'(coef.xx) * apr_pkg::PROD_W'(corner_reg.x1);
        prod_next.xy0 = apr_pkg::PROD_W'(coef.xy) * apr_pkg::PROD_W'(corner_reg.y0);
        prod_next.xy1 = apr_pkg::PROD_W'(coef.xy) * apr_pkg::PROD_W'(corner_reg.y1);
        prod_next.yx0 = apr_pkg::PROD_W'(coef.yx) * apr_pkg::PROD_W'(corner_reg.x0);
        prod_next.yx1 = apr_pkg::PROD_W'(coef.yx) * apr_pkg::PROD_W'(corner_reg.x1);
        prod_next.yy0 = apr_pkg::PROD_W'(coef.yy) * apr_pkg::PROD_W'(corner_reg.y0);
        prod_next.yy1 = apr_pkg::PROD_W'(coef.yy) * apr_pkg::PROD_W'(corner_reg.y1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_vld_reg <= 1'b0;
            prod_vld_reg   <= 1'b0;
        end
        else if (en)
        begin
            corner_vld_reg <= in_valid;
            prod_vld_reg   <= corner_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            corner_reg <= corner_next;
            prod_reg   <= prod_next;
        end
    end

    assign out_valid = prod_vld_reg;
    assign prod      = prod_reg;

endmodule

// File: rtl/apr_bound.sv
// Stage 3: floor and per-term min/max. Stage 4: sums with saturation.
// Stage 5: box size. Saturation is monotone, and each output coordinate is
// a sum of one x term and one y term, so the box edges come from the term
// extremes directly.
module apr_bound #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  apr_pkg::prod_t                      prod,
    input  logic signed [apr_pkg::COORD_W-1:0]  coef_xt,
    input  logic signed [apr_pkg::COORD_W-1:0]  coef_yt,
    output logic                                out_valid,
    output apr_pkg::result_t                    result
);

    localparam int PW = apr_pkg::PROD_W - FRAC_BITS;
    localparam int SW = PW + 2;
    localparam int CW = apr_pkg::COORD_W;

    typedef struct packed {
        logic signed [PW-1:0] ax_min;
        logic signed [PW-1:0] ax_max;
        logic signed [PW-1:0] bx_min;
        logic signed [PW-1:0] bx_max;
        logic signed [PW-1:0] ay_min;
        logic signed [PW-1:0] ay_max;
        logic signed [PW-1:0] by_min;
        logic signed [PW-1:0] by_max;
    } ext_t;

    typedef struct packed {
        logic signed [CW-1:0] lo_x;
        logic signed [CW-1:0] hi_x;
        logic signed [CW-1:0] lo_y;
        logic signed [CW-1:0] hi_y;
    } edge_t;

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [SW-1:0] v);
        logic [SW-CW:0] top;
        top = v[SW-1:CW-1];
        if ((&top) || !(|top))
            return v[CW-1:0];
        else if (v[SW-1])
            return apr_pkg::S32_MIN;
        else
            return apr_pkg::S32_MAX;
    endfunction

    function automatic logic [apr_pkg::SIZE_W-1:0] sat_size(
        input logic signed [CW-1:0] hi,
        input logic signed [CW-1:0] lo
    );
        logic signed [CW:0] d;
        d = {hi[CW-1], hi} - {lo[CW-1], lo};
        // hi >= lo, so d is never negative
        if (d[CW:CW-1] != 2'b00)
            return apr_pkg::U31_MAX;
        else
            return d[apr_pkg::SIZE_W-1:0];
    endfunction

    logic signed [PW-1:0] f_xx0, f_xx1, f_xy0, f_xy1, f_yx0, f_yx1, f_yy0, f_yy1;

    ext_t             ext_reg;
    ext_t             ext_next;
    logic             ext_vld_reg;
    edge_t            edge_reg;
    edge_t            edge_next;
    logic             edge_vld_reg;
    apr_pkg::result_t res_reg;
    apr_pkg::result_t res_next;
    logic             res_vld_reg;

    // dropping low bits of a two's complement value floors it
    assign f_xx0 = prod.xx0[apr_pkg::PROD_W-1:FRAC_BITS];
    assign f_xx1 = prod.xx1[apr_pkg::PROD_W-1:FRAC_BITS];
    assign f_xy0 = prod.xy0[apr_pkg::PROD_W-1:FRAC_BITS];
    assign f_xy1 = prod.xy1[apr_pkg::PROD_W-1:FRAC_BITS];
    assign f_yx0 = prod.yx0[apr_pkg::PROD_W-1:FRAC_BITS];
    assign f_yx1 = prod.yx1[apr_pkg::PROD_W-1:FRAC_BITS];
    assign f_yy0 = prod.yy0[apr_pkg::PROD_W-1:FRAC_BITS];
    assign f_yy1 = prod.yy1[apr_pkg::PROD_W-1:FRAC_BITS];

    always_comb
    begin
        ext_next.ax_min = (f_xx1 < f_xx0) ? f_xx1 : f_xx0;
        ext_next.ax_max = (f_xx1 < f_xx0) ? f_xx0 : f_xx1;
        ext_next.bx_min = (f_xy1 < f_xy0) ? f_xy1 : f_xy0;
        ext_next.bx_max = (f_xy1 < f_xy0) ? f_xy0 : f_xy1;
        ext_next.ay_min = (f_yx1 < f_yx0) ? f_yx1 : f_yx0;
        ext_next.ay_max = (f_yx1 < f_yx0) ? f_yx0 : f_yx1;
        ext_next.by_min = (f_yy1 < f_yy0) ? f_yy1 : f_yy0;
        ext_next.by_max = (f_yy1 < f_yy0) ? f_yy0 : f_yy1;
    end

    always_comb
    begin
        edge_next.lo_x = sat_coord(SW'(ext_reg.ax_min) + SW'(ext_reg.bx_min) + SW'(coef_xt));
        edge_next.hi_x = sat_coord(SW'(ext_reg.ax_max) + SW'(ext_reg.bx_max) + SW'(coef_xt));
        edge_next.lo_y = sat_coord(SW'(ext_reg.ay_min) + SW'(ext_reg.by_min) + SW'(coef_yt));
        edge_next.hi_y = sat_coord(SW'(ext_reg.ay_max) + SW'(ext_reg.by_max) + SW'(coef_yt));
    end

    always_comb
    begin
        res_next.out_x = edge_reg.lo_x;
        res_next.out_y = edge_reg.lo_y;
        res_next.out_w = sat_size(edge_reg.hi_x, edge_reg.lo_x);
        res_next.out_h = sat_size(edge_reg.hi_y, edge_reg.lo_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_vld_reg  <= 1'b0;
            edge_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else if (en)
        begin
            ext_vld_reg  <= in_valid;
            edge_vld_reg <= ext_vld_reg;
            res_vld_reg  <= edge_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ext_reg  <= ext_next;
            edge_reg <= edge_next;
            res_reg  <= res_next;
        end
    end

    assign out_valid = res_vld_reg;
    assign result    = res_reg;

endmodule

// File: rtl/affine_point_rect_transform_unit.sv
// Channel  Dir  Payload                                   Handshake
// item     in   mode, pos_x, pos_y, size_w, size_h        valid/ready
// result   out  out_x, out_y, out_w, out_h                valid/ready
// cfg      in   index (0..5, others dropped), data        valid/ready (ready held high)
//
// Five register stages: far edges, multiply, floor/min-max, sum, box size.
// One request per cycle is accepted while the output is not stalled.
// All stages hold together while a finished result waits (item.ready low).
// Reset clears valid bits and loads the identity transform.
module affine_point_rect_transform_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    apr_item_if.sink    item,
    apr_result_if.source result,
    apr_cfg_if.sink     cfg
);

    apr_pkg::coef_set_t coef;
    apr_pkg::prod_t     prod;
    apr_pkg::result_t   res;
    logic               prod_valid;
    logic               res_valid;
    logic               advance;

    assign advance = !res_valid || result.ready;

    assign cfg.ready  = 1'b1;
    assign item.ready = advance;

    apr_coef_regs u_coef (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .coef     (coef)
    );

    apr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (item.valid),
        .mode      (item.mode),
        .pos_x     (item.pos_x),
        .pos_y     (item.pos_y),
        .size_w    (item.size_w),
        .size_h    (item.size_h),
        .coef      (coef),
        .out_valid (prod_valid),
        .prod      (prod)
    );

    apr_bound #(
        .FRAC_BITS (FRAC_BITS)
    ) u_bound (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (prod_valid),
        .prod      (prod),
        .coef_xt   (coef.xt),
        .coef_yt   (coef.yt),
        .out_valid (res_valid),
        .result    (res)
    );

    assign result.valid = res_valid;
    assign result.out_x = res.out_x;
    assign result.out_y = res.out_y;
    assign result.out_w = res.out_w;
    assign result.out_h = res.out_h;

endmodule

// File: rtl/apr_checker.sv
module apr_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic                               res_valid,
    input  logic                               res_ready,
    input  logic signed [apr_pkg::COORD_W-1:0] out_x,
    input  logic signed [apr_pkg::COORD_W-1:0] out_y,
    input  logic [apr_pkg::SIZE_W-1:0]         out_w,
    input  logic [apr_pkg::SIZE_W-1:0]         out_h
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(out_x) && $stable(out_y)
                                    && $stable(out_w) && $stable(out_h))
        else $error("stalled result changed");

    // nothing waiting at the output: the pipe must take a request
    assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> in_ready)
        else $error("input blocked with empty output");

    // a request reaches the output when the sink keeps taking
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready ##1 res_ready ##1 res_ready ##1 res_ready ##1 res_ready)
        |=> res_valid)
        else $error("request did not reach the output in five cycles");

    // output ready always frees the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        res_ready |-> in_ready)
        else $error("input blocked while output drains");

endmodule

bind affine_point_rect_transform_unit apr_checker u_apr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .out_x     (result.out_x),
    .out_y     (result.out_y),
    .out_w     (result.out_w),
    .out_h     (result.out_h)
);

// File: tb/apr_transform_check.sv
module apr_transform_check #(
    parameter int FRAC_BITS = 16
) (
    input  logic  clk,
    input  logic  rst_n,
    apr_item_if   item,
    apr_result_if result,
    apr_cfg_if    cfg,
    output int    mismatches,
    output int    in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    apr_pkg::coef_set_t coefs;
    apr_pkg::result_t   expected_boxes[$];

    function automatic longint clamp32(longint v);
        if (v > longint'(apr_pkg::S32_MAX))
            return longint'(apr_pkg::S32_MAX);
        if (v < longint'(apr_pkg::S32_MIN))
            return longint'(apr_pkg::S32_MIN);
        return v;
    endfunction

    // each product floored on its own, then exact sum with the offset
    function automatic longint affine_axis(logic signed [apr_pkg::COORD_W-1:0] ka,
                                           logic signed [apr_pkg::COORD_W-1:0] kb,
                                           logic signed [apr_pkg::COORD_W-1:0] kt,
                                           longint a, longint b);
        longint pa;
        longint pb;
        pa = (longint'(ka) * a) >>> FRAC_BITS;
        pb = (longint'(kb) * b) >>> FRAC_BITS;
        return clamp32(pa + pb + longint'(kt));
    endfunction

    function automatic apr_pkg::result_t transform_item(
        apr_pkg::coef_set_t k, logic rect,
        logic signed [apr_pkg::COORD_W-1:0] px,
        logic signed [apr_pkg::COORD_W-1:0] py,
        logic [apr_pkg::SIZE_W-1:0] w,
        logic [apr_pkg::SIZE_W-1:0] h
    );
        apr_pkg::result_t r;
        longint  x0, x1, y0, y1, cx, cy, mx, my;
        longint  lo_x, hi_x, lo_y, hi_y, span_x, span_y;
        x0 = px;
        y0 = py;
        if (rect)
        begin
            x1 = clamp32(x0 + longint'(w));
            y1 = clamp32(y0 + longint'(h));
        end
        else
        begin
            x1 = x0;
            y1 = y0;
        end
        lo_x = 0;
        hi_x = 0;
        lo_y = 0;
        hi_y = 0;
        // corners in order: near/near, far/near, far/far, near/far
        for (int c = 0; c < 4; c++)
        begin
            cx = (c == 1 || c == 2) ? x1 : x0;
            cy = (c >= 2) ? y1 : y0;
            mx = affine_axis(k.xx, k.xy, k.xt, cx, cy);
            my = affine_axis(k.yx, k.yy, k.yt, cx, cy);
            if (c == 0 || mx < lo_x)
                lo_x = mx;
            if (c == 0 || mx > hi_x)
                hi_x = mx;
            if (c == 0 || my < lo_y)
                lo_y = my;
            if (c == 0 || my > hi_y)
                hi_y = my;
        end
        span_x = hi_x - lo_x;
        span_y = hi_y - lo_y;
        if (span_x > longint'(apr_pkg::U31_MAX))
            span_x = longint'(apr_pkg::U31_MAX);
        if (span_y > longint'(apr_pkg::U31_MAX))
            span_y = longint'(apr_pkg::U31_MAX);
        r.out_x = lo_x[apr_pkg::COORD_W-1:0];
        r.out_y = lo_y[apr_pkg::COORD_W-1:0];
        r.out_w = span_x[apr_pkg::SIZE_W-1:0];
        r.out_h = span_y[apr_pkg::SIZE_W-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        apr_pkg::result_t got;
        apr_pkg::result_t want;
        if (!rst_n)
        begin
            coefs = '{xx: apr_pkg::COEF_ONE_RST, xy: apr_pkg::COEF_ZERO_RST,
                      xt: apr_pkg::COEF_ZERO_RST, yx: apr_pkg::COEF_ZERO_RST,
                      yy: apr_pkg::COEF_ONE_RST, yt: apr_pkg::COEF_ZERO_RST};
            expected_boxes.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    apr_pkg::COEF_XX: coefs.xx = cfg.data;
                    apr_pkg::COEF_XY: coefs.xy = cfg.data;
                    apr_pkg::COEF_XT: coefs.xt = cfg.data;
                    apr_pkg::COEF_YX: coefs.yx = cfg.data;
                    apr_pkg::COEF_YY: coefs.yy = cfg.data;
                    apr_pkg::COEF_YT: coefs.yt = cfg.data;
                    default: ;
                endcase
            end
            if (item.valid && item.ready)
                expected_boxes.push_back(transform_item(coefs, item.mode, item.pos_x,
                                                        item.pos_y, item.size_w,
                                                        item.size_h));
            if (result.valid && result.ready)
            begin
                got = '{out_x: result.out_x, out_y: result.out_y,
                        out_w: result.out_w, out_h: result.out_h};
                if (expected_boxes.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: expected no result, got x=%0d y=%0d w=%0d h=%0d",
                             $time, got.out_x, got.out_y, got.out_w, got.out_h);
                end
                else
                begin
                    want = expected_boxes.pop_front();
                    if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
                        got.out_w !== want.out_w || got.out_h !== want.out_h)
                    begin
                        mismatches++;
                        $display({"%0t: mismatch expected x=%0d y=%0d w=%0d h=%0d,",
                                  " got x=%0d y=%0d w=%0d h=%0d"},
                                 $time, want.out_x, want.out_y, want.out_w, want.out_h,
                                 got.out_x, got.out_y, got.out_w, got.out_h);
                    end
                end
            end
        end
        in_flight <= expected_boxes.size();
    end

endmodule

// File: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC           = 16;
    localparam int PIPE_LAT       = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int NUM_PHASES     = 6;
    localparam int PHASE_ITEMS    = 230;

    // indexes past the last coefficient; writes there are dropped
    localparam logic [apr_pkg::COEF_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [apr_pkg::COEF_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    localparam logic MODE_POINT = 1'b0;
    localparam logic MODE_RECT  = 1'b1;

    logic clk = 1'b0;
    logic rst_n;

    int   errors;
    int   pending;
    int   tx_idle_pct = 29;
    int   rx_idle_pct = 61;
    logic rx_hold_go = 1'b0;
    logic rx_hold_used = 1'b0;
    int   rx_hold_left = 0;
    int   quiet_cycles = 0;

    apr_item_if   item();
    apr_result_if result();
    apr_cfg_if    cfg();

    affine_point_rect_transform_unit #(.FRAC_BITS(FRAC)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );

    apr_transform_check #(.FRAC_BITS(FRAC)) box_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .result     (result),
        .cfg        (cfg),
        .mismatches (errors),
        .in_flight  (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver: random stalls, plus one long hold-off when requested
    always @(posedge clk)
    begin
        if (rx_hold_left != 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
            result.ready <= 1'b0;
        end
        else if (rx_hold_go && !rx_hold_used)
        begin
            rx_hold_used <= 1'b1;
            rx_hold_left <= HOLD_CYCLES;
            result.ready <= 1'b0;
        end
        else
            result.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item.valid && item.ready) || (result.valid && result.ready) ||
            (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [apr_pkg::COORD_W-1:0] pick_coef();
        case ($urandom_range(9))
            0: return apr_pkg::S32_MAX;
            1: return apr_pkg::S32_MIN;
            2: return apr_pkg::COEF_ZERO_RST;
            3: return apr_pkg::COEF_ONE_RST;
            4: return -apr_pkg::COEF_ONE_RST;
            5, 6: return $urandom_range(0, 524288) - 262144;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [apr_pkg::COORD_W-1:0] pick_coord();
        case ($urandom_range(9))
            0: return apr_pkg::S32_MAX;
            1: return apr_pkg::S32_MIN;
            2: return '0;
            3: return 32'hFFFF_FFFF;
            4, 5: return $urandom_range(0, 16777216) - 8388608;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [apr_pkg::SIZE_W-1:0] pick_size();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(7))
            0: return apr_pkg::U31_MAX;
            1: return '0;
            2, 3: return apr_pkg::SIZE_W'(r[21:0]);
            default: return r[apr_pkg::SIZE_W-1:0];
        endcase
    endfunction

    task automatic send_item(input logic m, input logic [apr_pkg::COORD_W-1:0] x,
                             input logic [apr_pkg::COORD_W-1:0] y,
                             input logic [apr_pkg::SIZE_W-1:0] w,
                             input logic [apr_pkg::SIZE_W-1:0] h);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid  <= 1'b1;
        item.mode   <= m;
        item.pos_x  <= x;
        item.pos_y  <= y;
        item.size_w <= w;
        item.size_h <= h;
        do
            @(posedge clk);
        while (!item.ready);
    endtask

    task automatic write_reg(input logic [apr_pkg::COEF_IDX_W-1:0] idx,
                             input logic [apr_pkg::COORD_W-1:0] d);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= d;
        do
            @(posedge clk);
        while (!cfg.ready);
    endtask

    task automatic load_coefs(input apr_pkg::coef_set_t k);
        write_reg(apr_pkg::COEF_XX, k.xx);
        write_reg(apr_pkg::COEF_XY, k.xy);
        write_reg(apr_pkg::COEF_XT, k.xt);
        write_reg(apr_pkg::COEF_YX, k.yx);
        write_reg(apr_pkg::COEF_YY, k.yy);
        write_reg(apr_pkg::COEF_YT, k.yt);
        write_reg(IDX_SPARE_LO, $urandom());
        write_reg(IDX_SPARE_HI, $urandom());
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // stop offering and wait until every request has come back
    task automatic drain();
        item.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (PIPE_LAT) @(posedge clk);
    endtask

    initial
    begin
        apr_pkg::coef_set_t k;
        rst_n        = 1'b0;
        item.valid   = 1'b0;
        item.mode    = MODE_POINT;
        item.pos_x   = '0;
        item.pos_y   = '0;
        item.size_w  = '0;
        item.size_h  = '0;
        result.ready = 1'b0;
        cfg.valid    = 1'b0;
        cfg.index    = apr_pkg::COEF_XX;
        cfg.data     = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // identity map after reset; far edges at both ends of the range, saturation at the top
        send_item(MODE_POINT, '0, '0, '0, '0);
        send_item(MODE_POINT, apr_pkg::S32_MAX, apr_pkg::S32_MIN, apr_pkg::U31_MAX,
                  apr_pkg::U31_MAX);
        send_item(MODE_POINT, apr_pkg::S32_MIN, apr_pkg::S32_MAX, '0, '0);
        send_item(MODE_POINT, 32'hFFFF_FFFF, 32'd1, '0, '0);
        send_item(MODE_RECT, '0, '0, '0, '0);
        send_item(MODE_RECT, apr_pkg::S32_MAX, apr_pkg::S32_MAX, apr_pkg::U31_MAX,
                  apr_pkg::U31_MAX);
        send_item(MODE_RECT, apr_pkg::S32_MIN, apr_pkg::S32_MIN, apr_pkg::U31_MAX,
                  apr_pkg::U31_MAX);
        send_item(MODE_RECT, -32'sd65536, -32'sd65536, 31'd131072, 31'd131072);
        send_item(MODE_RECT, 32'd1, 32'hFFFF_FFFF, 31'd1, 31'd1);
        drain();

        // largest coefficients: sum saturation and box width clamp
        load_coefs('{default: apr_pkg::S32_MAX});
        send_item(MODE_POINT, 32'd1, 32'd1, '0, '0);
        send_item(MODE_POINT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0);
        send_item(MODE_POINT, apr_pkg::S32_MAX, apr_pkg::S32_MAX, '0, '0);
        send_item(MODE_POINT, apr_pkg::S32_MIN, apr_pkg::S32_MAX, '0, '0);
        send_item(MODE_RECT, apr_pkg::S32_MIN, apr_pkg::S32_MIN, apr_pkg::U31_MAX,
                  apr_pkg::U31_MAX);
        drain();

        load_coefs('{default: apr_pkg::S32_MIN});
        send_item(MODE_POINT, apr_pkg::S32_MAX, apr_pkg::S32_MAX, '0, '0);
        send_item(MODE_POINT, apr_pkg::S32_MIN, apr_pkg::S32_MIN, '0, '0);
        send_item(MODE_RECT, '0, '0, apr_pkg::U31_MAX, apr_pkg::U31_MAX);
        send_item(MODE_POINT, 32'hFFFF_FFFF, 32'd1, '0, '0);
        drain();

        // half and tiny weights: negative products must floor
        load_coefs('{xx: 32'sh0000_8000, xy: -32'sh0000_8000, xt: apr_pkg::COEF_ZERO_RST,
                     yx: -32'sd1, yy: 32'sd1, yt: apr_pkg::S32_MIN});
        send_item(MODE_POINT, 32'd1, 32'd1, '0, '0);
        send_item(MODE_POINT, 32'd3, -32'sd3, '0, '0);
        send_item(MODE_RECT, -32'sd5, 32'd7, 31'd10, 31'd3);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain();
            if (ph == 2)
            begin
                tx_idle_pct = 61;
                rx_idle_pct <= 29;
            end
            if (ph == 4)
            begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
                rx_hold_go  <= 1'b1;
            end
            k.xx = pick_coef();
            k.xy = pick_coef();
            k.xt = pick_coef();
            k.yx = pick_coef();
            k.yy = pick_coef();
            k.yt = pick_coef();
            load_coefs(k);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(1'($urandom_range(1)), pick_coord(), pick_coord(), pick_size(),
                          pick_size());
        end
        drain();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
